/* hdl/isst_pkg.sv */
// Shared types and codes for the interval set subtract table.
package isst_pkg;

	// Request codes carried by req_type.
	localparam logic [1:0] REQ_SUBTRACT = 2'd0;
	localparam logic [1:0] REQ_QUERY    = 2'd1;
	localparam logic [1:0] REQ_RESTART  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_INITIAL_LOW  = 1'b0;
	localparam logic CFG_INITIAL_HIGH = 1'b1;

	localparam int unsigned VALUE_W = 32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RESTART,
		ST_WALK_RD,
		ST_WALK_EV,
		ST_SPLIT_B,
		ST_SH_RD,
		ST_SH_WR,
		ST_SPLIT_B_SH,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_Q_RD,
		ST_Q_EV,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_RESTART,
		OP_READ_RD,
		OP_READ_K,
		OP_KEEP,
		OP_REMOVE,
		OP_CLIP_HI,
		OP_CLIP_LO,
		OP_SPLIT_A,
		OP_SPLIT_B,
		OP_OVF,
		OP_SHIFT,
		OP_QUERY,
		OP_LOAD_OUT
	} op_t;

	// How the entry under the walk relates to the range being removed.
	typedef enum logic [2:0] {
		CL_KEEP,
		CL_COVER,
		CL_CLIP_HI,
		CL_CLIP_LO,
		CL_SPLIT
	} seg_class_t;

	typedef struct packed {
		logic       rd_lt_end;
		logic       wr_eq_rd;
		logic       k_gt_wr;
		logic       full;
		seg_class_t cls;
	} dp_status_t;

endpackage

/* hdl/isst_datapath.sv */
// Segment store, walk pointers, length accumulator and result registers.
module isst_datapath #(
	parameter int unsigned MAX_SEGMENTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  isst_pkg::op_t                     op,
	input  logic signed [31:0]                start_value,
	input  logic signed [31:0]                end_value,
	input  logic signed [31:0]                init_low,
	input  logic signed [31:0]                init_high,
	output isst_pkg::dp_status_t              status,
	output logic                              is_inside,
	output logic [$clog2(MAX_SEGMENTS+1)-1:0] segment_count,
	output logic [31:0]                       total_length,
	output logic                              overflow
);
	import isst_pkg::*;

	localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

	logic signed [31:0] lo_mem [MAX_SEGMENTS];
	logic signed [31:0] hi_mem [MAX_SEGMENTS];

	logic signed [31:0] rlo_q, rhi_q;
	logic signed [31:0] f_q, t_q, split_hi_q;
	logic [CW-1:0]      cnt_q, end_q, rd_q, wr_q, k_q;
	logic [31:0]        sum_q;
	logic               inside_q, ovf_q;

	logic               is_inside_q, overflow_q;
	logic [CW-1:0]      count_out_q;
	logic [31:0]        length_out_q;

	logic               we, re;
	logic [CW-1:0]      waddr_c, raddr_c;
	logic signed [31:0] wlo, whi;
	logic [31:0]        add_a, add_b, sum_next;
	logic               pt_hit;
	seg_class_t         cls;

	// classification in the priority order of the walk
	always_comb begin
		if (f_q > rhi_q || t_q < rlo_q)
			cls = CL_KEEP;
		else if (rlo_q >= f_q && rhi_q <= t_q)
			cls = CL_COVER;
		else if (f_q > rlo_q && f_q < rhi_q && t_q >= rhi_q)
			cls = CL_CLIP_HI;
		else if (t_q > rlo_q && t_q <= rhi_q && f_q <= rlo_q)
			cls = CL_CLIP_LO;
		else if (f_q > rlo_q && t_q < rhi_q)
			cls = CL_SPLIT;
		else
			cls = CL_KEEP;
	end

	assign pt_hit = (rlo_q < f_q) && (rhi_q > f_q);

	assign status.rd_lt_end = rd_q < end_q;
	assign status.wr_eq_rd  = wr_q == rd_q;
	assign status.k_gt_wr   = k_q > wr_q;
	assign status.full      = cnt_q == CW'(MAX_SEGMENTS);
	assign status.cls       = cls;

	// memory port steering
	always_comb begin
		we      = 1'b0;
		waddr_c = wr_q;
		wlo     = rlo_q;
		whi     = rhi_q;
		case (op)
			OP_KEEP: begin
				we = 1'b1;
			end
			OP_CLIP_HI, OP_SPLIT_A: begin
				we  = 1'b1;
				whi = f_q;
			end
			OP_CLIP_LO: begin
				we  = 1'b1;
				wlo = t_q;
			end
			OP_SPLIT_B: begin
				we      = 1'b1;
				waddr_c = wr_q + CW'(1);
				wlo     = t_q;
				whi     = split_hi_q;
			end
			OP_SHIFT: begin
				we      = 1'b1;
				waddr_c = k_q + CW'(1);
			end
			OP_RESTART: begin
				we      = 1'b1;
				waddr_c = '0;
				wlo     = init_low;
				whi     = init_high;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign re      = (op == OP_READ_RD) || (op == OP_READ_K);
	assign raddr_c = (op == OP_READ_K) ? k_q : rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			lo_mem[waddr_c[IW-1:0]] <= wlo;
			hi_mem[waddr_c[IW-1:0]] <= whi;
		end
		if (re) begin
			rlo_q <= lo_mem[raddr_c[IW-1:0]];
			rhi_q <= hi_mem[raddr_c[IW-1:0]];
		end
	end

	// length delta: sum + a - b
	always_comb begin
		add_a = '0;
		add_b = '0;
		case (op)
			OP_REMOVE: begin
				add_a = rlo_q;
				add_b = rhi_q;
			end
			OP_CLIP_HI: begin
				add_a = f_q;
				add_b = rhi_q;
			end
			OP_CLIP_LO: begin
				add_a = rlo_q;
				add_b = t_q;
			end
			OP_SPLIT_A: begin
				add_a = f_q;
				add_b = t_q;
			end
			default: begin
				add_a = '0;
				add_b = '0;
			end
		endcase
	end

	assign sum_next = sum_q + add_a - add_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			sum_q    <= '0;
			end_q    <= '0;
			rd_q     <= '0;
			wr_q     <= '0;
			k_q      <= '0;
			inside_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			case (op)
				OP_CAPTURE: begin
					end_q    <= cnt_q;
					rd_q     <= '0;
					wr_q     <= '0;
					inside_q <= 1'b0;
					ovf_q    <= 1'b0;
				end
				OP_RESTART: begin
					cnt_q <= CW'(1);
					sum_q <= init_high - init_low;
				end
				OP_KEEP, OP_CLIP_HI: begin
					wr_q  <= wr_q + CW'(1);
					rd_q  <= rd_q + CW'(1);
					sum_q <= sum_next;
				end
				OP_CLIP_LO: begin
					wr_q  <= wr_q + CW'(1);
					rd_q  <= rd_q + CW'(1);
					sum_q <= sum_next;
				end
				OP_REMOVE: begin
					rd_q  <= rd_q + CW'(1);
					cnt_q <= cnt_q - CW'(1);
					sum_q <= sum_next;
				end
				OP_SPLIT_A: begin
					k_q   <= cnt_q - CW'(1);
					sum_q <= sum_next;
				end
				OP_SPLIT_B: begin
					wr_q  <= wr_q + CW'(2);
					rd_q  <= rd_q + CW'(1);
					cnt_q <= cnt_q + CW'(1);
				end
				OP_SHIFT: begin
					k_q <= k_q - CW'(1);
				end
				OP_OVF: begin
					ovf_q <= 1'b1;
				end
				OP_QUERY: begin
					rd_q     <= rd_q + CW'(1);
					inside_q <= inside_q | pt_hit;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// operands, kept split piece, result payload
	always_ff @(posedge clk) begin
		if (op == OP_CAPTURE) begin
			f_q <= start_value;
			t_q <= end_value;
		end
		if (op == OP_SPLIT_A)
			split_hi_q <= rhi_q;
		if (op == OP_LOAD_OUT) begin
			is_inside_q  <= inside_q;
			overflow_q   <= ovf_q;
			count_out_q  <= cnt_q;
			length_out_q <= sum_q;
		end
	end

	assign is_inside     = is_inside_q;
	assign overflow      = overflow_q;
	assign segment_count = count_out_q;
	assign total_length  = length_out_q;

endmodule

/* hdl/isst_ctrl.sv */
// Sequencer for restart, subtract walk, table shift and point query.
module isst_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           req_type,
	input  logic                 out_stall,
	input  isst_pkg::dp_status_t status,
	output isst_pkg::op_t        op,
	output logic                 in_stall,
	output logic                 out_valid
);
	import isst_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;
	logic   copy_go;

	assign out_free = !out_valid_q || !out_stall;
	assign copy_go  = status.rd_lt_end && !status.wr_eq_rd;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (req_type)
						REQ_SUBTRACT: state_nxt = ST_WALK_RD;
						REQ_QUERY:    state_nxt = ST_Q_RD;
						REQ_RESTART:  state_nxt = ST_RESTART;
						default:      state_nxt = ST_DONE;
					endcase
				end
			end
			ST_RESTART: state_nxt = ST_DONE;
			ST_WALK_RD: state_nxt = status.rd_lt_end ? ST_WALK_EV : ST_DONE;
			ST_WALK_EV: begin
				case (status.cls)
					CL_CLIP_LO: state_nxt = ST_COPY_RD;
					CL_SPLIT: begin
						if (status.full)
							state_nxt = ST_COPY_RD;
						else if (status.wr_eq_rd)
							state_nxt = ST_SH_RD;
						else
							state_nxt = ST_SPLIT_B;
					end
					default: state_nxt = ST_WALK_RD;
				endcase
			end
			ST_SPLIT_B:    state_nxt = ST_COPY_RD;
			ST_SH_RD:      state_nxt = status.k_gt_wr ? ST_SH_WR : ST_SPLIT_B_SH;
			ST_SH_WR:      state_nxt = ST_SH_RD;
			ST_SPLIT_B_SH: state_nxt = ST_DONE;
			ST_COPY_RD:    state_nxt = copy_go ? ST_COPY_WR : ST_DONE;
			ST_COPY_WR:    state_nxt = ST_COPY_RD;
			ST_Q_RD:       state_nxt = status.rd_lt_end ? ST_Q_EV : ST_DONE;
			ST_Q_EV:       state_nxt = ST_Q_RD;
			ST_DONE:       state_nxt = out_free ? ST_IDLE : ST_DONE;
			default:       state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		op = OP_NONE;
		case (state_q)
			ST_IDLE:    op = in_valid ? OP_CAPTURE : OP_NONE;
			ST_RESTART: op = OP_RESTART;
			ST_WALK_RD: op = status.rd_lt_end ? OP_READ_RD : OP_NONE;
			ST_WALK_EV: begin
				case (status.cls)
					CL_COVER:   op = OP_REMOVE;
					CL_CLIP_HI: op = OP_CLIP_HI;
					CL_CLIP_LO: op = OP_CLIP_LO;
					CL_SPLIT:   op = status.full ? OP_OVF : OP_SPLIT_A;
					default:    op = OP_KEEP;
				endcase
			end
			ST_SPLIT_B, ST_SPLIT_B_SH: op = OP_SPLIT_B;
			ST_SH_RD:   op = status.k_gt_wr ? OP_READ_K : OP_NONE;
			ST_SH_WR:   op = OP_SHIFT;
			ST_COPY_RD: op = copy_go ? OP_READ_RD : OP_NONE;
			ST_COPY_WR: op = OP_KEEP;
			ST_Q_RD:    op = status.rd_lt_end ? OP_READ_RD : OP_NONE;
			ST_Q_EV:    op = OP_QUERY;
			ST_DONE:    op = out_free ? OP_LOAD_OUT : OP_NONE;
			default:    op = OP_NONE;
		endcase
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (op == OP_LOAD_OUT)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* hdl/interval_set_subtract_table_unit.sv */
// Top level of the interval set subtract table: config registers, sequencer, datapath.
//
// Holds up to MAX_SEGMENTS signed Q16.16 segments [low,high] in order. A restart item
// (req_type 2) loads the configured segment; a subtract item (0) walks the table and
// removes, clips or splits segments against [start_value,end_value], raising overflow
// when a split finds the table full; a query item (1) reports whether start_value lies
// strictly inside a segment; req_type 3 changes nothing. Every item gives one result
// with the segment count and total length. Items are taken one at a time: in_stall
// stays high from acceptance until the result is loaded into the output register.
// Timing is set by the segment memory: each entry touched is first read into a register
// and then evaluated or written back. A query reads and tests every held segment; a
// subtract walks the entries, copies entries down after a removal and writes the second
// piece of a split; a split with no earlier removal instead shifts the following entries
// up before writing its second piece. A finished result waits in the output register
// while the next item is taken.
// The segment store has no reset; only entries below the count are ever read.
module interval_set_subtract_table_unit #(
	parameter int unsigned MAX_SEGMENTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        req_type,
	input  logic signed [31:0]                start_value,
	input  logic signed [31:0]                end_value,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              is_inside,
	output logic [$clog2(MAX_SEGMENTS+1)-1:0] segment_count,
	output logic [31:0]                       total_length,
	output logic                              overflow,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [31:0]                       cfg_data
);
	import isst_pkg::*;

	logic signed [31:0] initial_low_q, initial_high_q;
	op_t                op;
	dp_status_t         status;

	// Always taken; the user must write config only while the block is idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_low_q  <= 32'sd0;
			initial_high_q <= 32'sd411775;	// 2*pi in Q16.16
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INITIAL_LOW:  initial_low_q  <= cfg_data;
				CFG_INITIAL_HIGH: initial_high_q <= cfg_data;
				default:          initial_low_q  <= initial_low_q;
			endcase
		end
	end

	// Sequencer: decides each cycle's datapath operation from the walk status.
	isst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.out_stall (out_stall),
		.status    (status),
		.op        (op),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	// Datapath: segment memory, read/write pointers, running length, result regs.
	isst_datapath #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.start_value   (start_value),
		.end_value     (end_value),
		.init_low      (initial_low_q),
		.init_high     (initial_high_q),
		.status        (status),
		.is_inside     (is_inside),
		.segment_count (segment_count),
		.total_length  (total_length),
		.overflow      (overflow)
	);

`ifndef NO_ASSERTIONS
	// An accepted item always makes the block busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block took an item without going busy");

	// The table never reports more segments than it holds.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (segment_count <= ($clog2(MAX_SEGMENTS+1))'(MAX_SEGMENTS)))
		else $error("segment count above table size");

	// A dropped split only happens with a full, unchanged table.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |->
			(segment_count == ($clog2(MAX_SEGMENTS+1))'(MAX_SEGMENTS)))
		else $error("overflow with table not full");

	// A result never has both is_inside and overflow set.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_inside && overflow))
		else $error("is_inside and overflow both set");
`endif

endmodule
